@@ hdl/wac_pkg.sv @@
`timescale 1ns / 1ps
package wac_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_WINDOWS = 16;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = 11;
  localparam int WW = 5;
  localparam int SW = 24;
  localparam int RW = 64;
  localparam int LW = 10;
  localparam int DVW = 11;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LAG  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_WINDOW_COUNT = 2'd1;

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          issue;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          first;
    logic          last;
    logic [DVW-1:0] terms;
    logic [DVW-1:0] nwin;
    logic          acc_clr;
    logic          fin_start;
  } lane_ctrl_t;

  typedef struct packed {
    logic win_done;
    logic fin_done;
  } lane_stat_t;

endpackage

@@ hdl/windowed_autocorrelation_unit.sv @@
`timescale 1ns / 1ps
// Push and clear leave the block idle. A query divides the record length by the window
// count for the window width, then runs per window a multiply-accumulate over width - lag
// terms through the lane pipeline and a per-window division, then the final division
// and the channel mean. A store that is not full or a lag not below the width ends it
// early. One item is in work at a time. Synchronous active-low reset clears the fill
// count and sets sample_count to 1024 and window_count to 1; the store is kept.
module windowed_autocorrelation_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic signed [wac_pkg::SW-1:0] in_sample_x,
  input  logic signed [wac_pkg::SW-1:0] in_sample_y,
  input  logic signed [wac_pkg::SW-1:0] in_sample_z,
  input  logic [wac_pkg::LW-1:0]        in_lag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wac_pkg::LW-1:0]        out_lag_out,
  output logic signed [wac_pkg::RW-1:0] out_corr_x,
  output logic signed [wac_pkg::RW-1:0] out_corr_y,
  output logic signed [wac_pkg::RW-1:0] out_corr_z,
  output logic signed [wac_pkg::RW-1:0] out_corr_mean,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [wac_pkg::CW-1:0]        cfg_data
);
  import wac_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVW  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_WAITW = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_MERGE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  sc_r;
  logic [WW-1:0]  wc_r;
  logic [CW-1:0]  fill_r;
  logic [LW-1:0]  lag_r;
  logic [1:0]     st_r;
  logic [CW-1:0]  width_r;
  logic [DVW-1:0] terms_r;
  logic [CW-1:0]  base_r;
  logic [CW-1:0]  a_r;
  logic [CW-1:0]  t_r;
  logic [WW-1:0]  w_r;
  logic           out_valid_r;
  logic [LW-1:0]  out_lag_r;
  logic signed [RW-1:0] out_x_r, out_y_r, out_z_r, out_m_r;
  logic [1:0]     out_st_r;

  logic [CW-1:0]  n_eff;
  logic [WW-1:0]  nw_eff;
  logic           in_xfer;
  logic           cfg_xfer;
  logic           wdiv_start;
  logic           wdiv_done;
  logic signed [RW-1:0] wdiv_q;
  logic [CW-1:0]  width_q;
  logic [CW-1:0]  b_addr;
  logic           out_load;
  logic           merge_start;
  logic           merge_done;
  logic signed [RW-1:0] mean;
  logic signed [RW-1:0] res_x, res_y, res_z;
  lane_ctrl_t     ctrl;
  lane_stat_t     stat_x, stat_y, stat_z;

  always_comb begin
    if (sc_r < CW'(2)) begin
      n_eff = CW'(2);
    end else if (sc_r > CW'(MAX_SAMPLES)) begin
      n_eff = CW'(MAX_SAMPLES);
    end else begin
      n_eff = sc_r;
    end
    if (wc_r == '0) begin
      nw_eff = WW'(1);
    end else if (wc_r > WW'(MAX_WINDOWS)) begin
      nw_eff = WW'(MAX_WINDOWS);
    end else begin
      nw_eff = wc_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign width_q   = wdiv_q[CW-1:0];
  assign b_addr    = a_r + CW'(lag_r);

  assign wdiv_start = in_xfer && in_command == CMD_QUERY && fill_r >= n_eff;

  wac_div u_wdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (wdiv_start),
    .dividend (RW'(n_eff)),
    .divisor  (DVW'(nw_eff)),
    .done     (wdiv_done),
    .quotient (wdiv_q)
  );

  always_comb begin
    ctrl.wr_en     = in_xfer && in_command == CMD_PUSH && fill_r < n_eff;
    ctrl.wr_addr   = fill_r[AW-1:0];
    ctrl.issue     = (state_r == S_RUN);
    ctrl.addr_a    = a_r[AW-1:0];
    ctrl.addr_b    = b_addr[AW-1:0];
    ctrl.first     = (t_r == '0);
    ctrl.last      = (DVW'(t_r) == terms_r - DVW'(1));
    ctrl.terms     = terms_r;
    ctrl.nwin      = DVW'(nw_eff);
    ctrl.acc_clr   = (state_r == S_DIVW) && wdiv_done;
    ctrl.fin_start = (state_r == S_WAITW) && stat_x.win_done && (w_r == nw_eff - WW'(1));
  end

  assign merge_start = (state_r == S_FIN) && stat_x.fin_done;

  wac_lane u_lane_x (
    .clk (clk), .rst_n (rst_n), .ctrl (ctrl), .wr_data (in_sample_x),
    .stat (stat_x), .res (res_x)
  );
  wac_lane u_lane_y (
    .clk (clk), .rst_n (rst_n), .ctrl (ctrl), .wr_data (in_sample_y),
    .stat (stat_y), .res (res_y)
  );
  wac_lane u_lane_z (
    .clk (clk), .rst_n (rst_n), .ctrl (ctrl), .wr_data (in_sample_z),
    .stat (stat_z), .res (res_z)
  );

  wac_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (merge_start),
    .res_x (res_x),
    .res_y (res_y),
    .res_z (res_z),
    .done  (merge_done),
    .mean  (mean)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_command == CMD_QUERY) begin
          state_nxt = (fill_r < n_eff) ? S_DONE : S_DIVW;
        end
      end
      S_DIVW: begin
        if (wdiv_done) begin
          state_nxt = (CW'(lag_r) >= width_q) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (ctrl.last) begin
          state_nxt = S_WAITW;
        end
      end
      S_WAITW: begin
        if (stat_x.win_done) begin
          state_nxt = ctrl.fin_start ? S_FIN : S_RUN;
        end
      end
      S_FIN: begin
        if (stat_x.fin_done) begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (merge_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sc_r        <= CW'(MAX_SAMPLES);
      wc_r        <= WW'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_xfer) begin
        case (cfg_index)
          REG_SAMPLE_COUNT: sc_r <= cfg_data;
          REG_WINDOW_COUNT: wc_r <= cfg_data[WW-1:0];
          default: ;
        endcase
      end
      if (ctrl.wr_en) begin
        fill_r <= fill_r + CW'(1);
      end else if (in_xfer && in_command == CMD_CLEAR) begin
        fill_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_command == CMD_QUERY) begin
      lag_r <= in_lag;
      st_r  <= (fill_r < n_eff) ? ST_FULL : ST_OK;
    end
    if (state_r == S_DIVW && wdiv_done) begin
      width_r <= width_q;
      terms_r <= DVW'(width_q - CW'(lag_r));
      base_r  <= '0;
      a_r     <= '0;
      t_r     <= '0;
      w_r     <= '0;
      if (CW'(lag_r) >= width_q) begin
        st_r <= ST_LAG;
      end
    end
    if (state_r == S_RUN) begin
      a_r <= a_r + CW'(1);
      t_r <= t_r + CW'(1);
    end
    // Next window starts one width further on.
    if (state_r == S_WAITW && stat_x.win_done && !ctrl.fin_start) begin
      w_r    <= w_r + WW'(1);
      base_r <= base_r + width_r;
      a_r    <= base_r + width_r;
      t_r    <= '0;
    end
    if (out_load) begin
      out_lag_r <= lag_r;
      out_st_r  <= st_r;
      out_x_r   <= (st_r == ST_OK) ? res_x : '0;
      out_y_r   <= (st_r == ST_OK) ? res_y : '0;
      out_z_r   <= (st_r == ST_OK) ? res_z : '0;
      out_m_r   <= (st_r == ST_OK) ? mean : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lag_out   = out_lag_r;
  assign out_corr_x    = out_x_r;
  assign out_corr_y    = out_y_r;
  assign out_corr_z    = out_z_r;
  assign out_corr_mean = out_m_r;
  assign out_status    = out_st_r;

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_x == stat_y) && (stat_x == stat_z))
    else $error("lanes out of step");

  a_run_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (fill_r >= n_eff))
    else $error("correlation walk on a store that is not full");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_corr_x == '0 && out_corr_mean == '0))
    else $error("error result carries non-zero correlation");

  a_walk_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (b_addr < n_eff))
    else $error("lagged address beyond the record");

endmodule

@@ hdl/wac_div.sv @@
`timescale 1ns / 1ps
module wac_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [wac_pkg::RW-1:0] dividend,
  input  logic [wac_pkg::DVW-1:0]       divisor,
  output logic                          done,
  output logic signed [wac_pkg::RW-1:0] quotient
);
  import wac_pkg::*;

  logic           busy_r;
  logic           done_r;
  logic [5:0]     cnt_r;
  logic           neg_r;
  logic [RW-1:0]  mag_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] dvs_r;
  logic [DVW:0]   trial;
  logic           ge;
  logic [DVW-1:0] rem_nxt;

  // One quotient bit per cycle, restoring, on the magnitude of the dividend.
  always_comb begin
    trial   = {rem_r, mag_r[RW-1]};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= 6'd63;
      neg_r <= dividend[RW-1];
      mag_r <= dividend[RW-1] ? RW'(-dividend) : RW'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      mag_r <= {mag_r[RW-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

@@ hdl/wac_lane.sv @@
`timescale 1ns / 1ps
module wac_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wac_pkg::lane_ctrl_t           ctrl,
  input  logic signed [wac_pkg::SW-1:0] wr_data,
  output wac_pkg::lane_stat_t           stat,
  output logic signed [wac_pkg::RW-1:0] res
);
  import wac_pkg::*;

  logic signed [SW-1:0]   mem [MAX_SAMPLES];
  logic signed [SW-1:0]   da_r, db_r;
  logic                   v1_r, f1_r, l1_r;
  logic                   v2_r, f2_r, l2_r;
  logic signed [2*SW-1:0] prod_r;
  logic signed [RW-1:0]   sum_r;
  logic                   sum_done_r;
  logic signed [RW-1:0]   accw_r;
  logic signed [RW-1:0]   res_r;
  logic                   fin_mode_r;
  logic                   div_start;
  logic signed [RW-1:0]   div_dividend;
  logic [DVW-1:0]         div_divisor;
  logic                   div_done;
  logic signed [RW-1:0]   div_q;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    da_r <= mem[ctrl.addr_a];
    db_r <= mem[ctrl.addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      sum_done_r <= 1'b0;
      fin_mode_r <= 1'b0;
    end else begin
      v1_r       <= ctrl.issue;
      v2_r       <= v1_r;
      sum_done_r <= v2_r && l2_r;
      if (ctrl.acc_clr) begin
        fin_mode_r <= 1'b0;
      end else if (ctrl.fin_start) begin
        fin_mode_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    f1_r   <= ctrl.first;
    l1_r   <= ctrl.last;
    f2_r   <= f1_r;
    l2_r   <= l1_r;
    prod_r <= da_r * db_r;
    if (v2_r) begin
      sum_r <= f2_r ? RW'(prod_r) : sum_r + RW'(prod_r);
    end
    if (ctrl.acc_clr) begin
      accw_r <= '0;
    end else if (div_done && !fin_mode_r) begin
      accw_r <= accw_r + div_q;
    end
    if (div_done && fin_mode_r) begin
      res_r <= div_q;
    end
  end

  // The window sum is divided by its term count, the window total by the window count.
  // The last window's quotient arrives in the same cycle as the final division starts.
  assign div_start    = sum_done_r || ctrl.fin_start;
  assign div_dividend = ctrl.fin_start ? accw_r + div_q : sum_r;
  assign div_divisor  = ctrl.fin_start ? ctrl.nwin : ctrl.terms;

  wac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.win_done = div_done && !fin_mode_r;
  assign stat.fin_done = div_done && fin_mode_r;
  assign res           = res_r;

endmodule

@@ hdl/wac_merge.sv @@
`timescale 1ns / 1ps
module wac_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [wac_pkg::RW-1:0] res_x,
  input  logic signed [wac_pkg::RW-1:0] res_y,
  input  logic signed [wac_pkg::RW-1:0] res_z,
  output logic                          done,
  output logic signed [wac_pkg::RW-1:0] mean
);
  import wac_pkg::*;

  // Reciprocal of three, exact for every 18-bit partial dividend.
  localparam logic [17:0] RECIP3 = 18'd174763;

  logic                 go_r;
  logic                 ld_r;
  logic                 busy_r;
  logic                 done_r;
  logic [1:0]           cnt_r;
  logic                 neg_r;
  logic [RW-1:0]        mag_r;
  logic [1:0]           rem_r;
  logic signed [RW-1:0] sum_r;
  logic [17:0]          part;
  logic [35:0]          prod;
  logic [15:0]          q_d;
  logic [17:0]          rem_full;

  // Long division by three, one 16-bit digit per cycle from the top.
  always_comb begin
    part     = {rem_r, mag_r[RW-1 -: 16]};
    prod     = part * RECIP3;
    q_d      = prod[34:19];
    rem_full = part - (18'({q_d, 1'b0}) + 18'(q_d));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r   <= 1'b0;
      ld_r   <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      go_r   <= start;
      ld_r   <= go_r;
      done_r <= 1'b0;
      if (ld_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 2'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_r) begin
      sum_r <= res_x + res_y + res_z;
    end
    if (ld_r) begin
      neg_r <= sum_r[RW-1];
      mag_r <= sum_r[RW-1] ? RW'(-sum_r) : RW'(sum_r);
      rem_r <= '0;
      cnt_r <= 2'd3;
    end else if (busy_r) begin
      mag_r <= {mag_r[RW-17:0], q_d};
      rem_r <= rem_full[1:0];
      cnt_r <= cnt_r - 2'd1;
    end
  end

  assign done = done_r;
  assign mean = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

@@ tb/tb_windowed_autocorrelation_unit.sv @@
`timescale 1ns / 1ps
module tb_windowed_autocorrelation_unit;
  import wac_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 540;

  typedef struct {
    logic [LW-1:0] lag;
    longint        cx;
    longint        cy;
    longint        cz;
    longint        cm;
    logic [1:0]    status;
  } corr_result_t;

  class corr_scoreboard;
    int                  errors = 0;
    logic signed [SW-1:0] sx[MAX_SAMPLES], sy[MAX_SAMPLES], sz[MAX_SAMPLES];
    int unsigned         fill = 0;
    logic [CW-1:0]       sample_count = 11'd1024;
    logic [WW-1:0]       window_count = 5'd1;
    corr_result_t        pending[$];

    function void write_reg(logic [1:0] idx, logic [CW-1:0] data);
      if (idx == REG_SAMPLE_COUNT) sample_count = data;
      else if (idx == REG_WINDOW_COUNT) window_count = data[WW-1:0];
    endfunction

    function int unsigned record_len();
      int unsigned n;
      n = sample_count;
      if (n < 2) n = 2;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      return n;
    endfunction

    function int unsigned windows();
      int unsigned w;
      w = window_count;
      if (w < 1) w = 1;
      if (w > MAX_WINDOWS) w = MAX_WINDOWS;
      return w;
    endfunction

    function longint channel_corr(int ch, int unsigned lag, int unsigned width,
                                  int unsigned nw);
      longint acc, sum, a, b;
      acc = 0;
      for (int unsigned w = 0; w < nw; w++) begin
        sum = 0;
        for (int unsigned t = 0; t + lag < width; t++) begin
          case (ch)
            0: begin a = sx[w*width+t]; b = sx[w*width+t+lag]; end
            1: begin a = sy[w*width+t]; b = sy[w*width+t+lag]; end
            default: begin a = sz[w*width+t]; b = sz[w*width+t+lag]; end
          endcase
          sum += a * b;
        end
        acc += sum / longint'(width - lag);
      end
      return acc / longint'(nw);
    endfunction

    function void note_input(logic [1:0] cmd, logic signed [SW-1:0] x,
                             logic signed [SW-1:0] y, logic signed [SW-1:0] z,
                             logic [LW-1:0] lag);
      corr_result_t r;
      int unsigned n, nw, width;
      n = record_len();
      if (cmd == CMD_PUSH) begin
        if (fill < n) begin
          sx[fill] = x; sy[fill] = y; sz[fill] = z;
          fill++;
        end
      end else if (cmd == CMD_CLEAR) begin
        fill = 0;
      end else if (cmd == CMD_QUERY) begin
        nw = windows();
        width = n / nw;
        r.lag = lag; r.cx = 0; r.cy = 0; r.cz = 0; r.cm = 0;
        if (fill < n) r.status = ST_FULL;
        else if (lag >= width) r.status = ST_LAG;
        else begin
          r.status = ST_OK;
          r.cx = channel_corr(0, lag, width, nw);
          r.cy = channel_corr(1, lag, width, nw);
          r.cz = channel_corr(2, lag, width, nw);
          r.cm = (r.cx + r.cy + r.cz) / 3;
        end
        pending.push_back(r);
      end
    endfunction

    function void check_result(corr_result_t got);
      corr_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer, lag_out %0d", got.lag);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.lag !== e.lag) begin
        $error("lag_out expected %0d actual %0d", e.lag, got.lag); errors++;
      end
      if (got.cx !== e.cx) begin
        $error("corr_x expected %0d actual %0d", e.cx, got.cx); errors++;
      end
      if (got.cy !== e.cy) begin
        $error("corr_y expected %0d actual %0d", e.cy, got.cy); errors++;
      end
      if (got.cz !== e.cz) begin
        $error("corr_z expected %0d actual %0d", e.cz, got.cz); errors++;
      end
      if (got.cm !== e.cm) begin
        $error("corr_mean expected %0d actual %0d", e.cm, got.cm); errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = CMD_PUSH;
  logic signed [SW-1:0] in_sample_x = '0, in_sample_y = '0, in_sample_z = '0;
  logic [LW-1:0] in_lag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LW-1:0] out_lag_out;
  logic signed [RW-1:0] out_corr_x, out_corr_y, out_corr_z, out_corr_mean;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_SAMPLE_COUNT;
  logic [CW-1:0] cfg_data = '0;

  corr_scoreboard sb = new();
  int idle_cycles = 0;
  int sent_items = 0;

  windowed_autocorrelation_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Result side: random stall before each transfer.
  initial begin
    int stall;
    corr_result_t got;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.lag = out_lag_out; got.cx = out_corr_x; got.cy = out_corr_y;
      got.cz = out_corr_z; got.cm = out_corr_mean; got.status = out_status;
      sb.check_result(got);
    end
  end

  task automatic send_item(logic [1:0] cmd, logic signed [SW-1:0] x,
                           logic signed [SW-1:0] y, logic signed [SW-1:0] z,
                           logic [LW-1:0] lag);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd; in_sample_x <= x; in_sample_y <= y; in_sample_z <= z;
    in_lag <= lag;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, x, y, z, lag);
    sent_items++;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic push_random();
    send_item(CMD_PUSH, rand_sample(), rand_sample(), rand_sample(), LW'($urandom));
  endtask

  task automatic query(logic [LW-1:0] lag);
    send_item(CMD_QUERY, SW'($urandom), SW'($urandom), SW'($urandom), lag);
  endtask

  // Registers change only once the block has drained and settled.
  task automatic write_cfg(logic [1:0] idx, logic [CW-1:0] data);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  initial begin
    int unsigned n, width, nq;
    logic signed [SW-1:0] maxv, minv;
    maxv = {1'b0, {(SW-1){1'b1}}};
    minv = {1'b1, {(SW-1){1'b0}}};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings leave the store not full; unused command ignored.
    query(10'd0);
    send_item(CMD_UNUSED, maxv, minv, maxv, 10'd1023);
    push_random();
    query(10'd1023);

    // Sample count below range behaves as two; window count zero as one.
    write_cfg(REG_SAMPLE_COUNT, 11'd0);
    write_cfg(REG_WINDOW_COUNT, 11'd0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_PUSH, maxv, minv, maxv, '0);
    send_item(CMD_PUSH, minv, maxv, minv, '0);
    send_item(CMD_PUSH, 24'sd1, 24'sd1, 24'sd1, '0);
    query(10'd0);
    query(10'd1);
    query(10'd2);
    query(10'd1023);

    // Oversized values clamp to the maximum record and window counts.
    write_cfg(REG_SAMPLE_COUNT, 11'd2047);
    write_cfg(REG_WINDOW_COUNT, 11'd31);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    push_random();
    query(10'd0);

    // More windows than samples gives a window width of zero.
    write_cfg(REG_SAMPLE_COUNT, 11'd3);
    write_cfg(REG_WINDOW_COUNT, 11'd16);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    repeat (3) push_random();
    query(10'd0);

    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        write_cfg(REG_SAMPLE_COUNT, CW'($urandom_range(49, 160)));
      else write_cfg(REG_SAMPLE_COUNT, CW'($urandom_range(0, 48)));
      if ($urandom_range(0, 7) == 0)
        write_cfg(REG_WINDOW_COUNT, CW'($urandom_range(17, 31)));
      else write_cfg(REG_WINDOW_COUNT, CW'($urandom_range(0, 6)));
      n = sb.record_len();
      width = n / sb.windows();
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      for (int unsigned i = 0; i < n + $urandom_range(0, 2); i++) begin
        case ($urandom_range(0, 39))
          0: send_item(CMD_UNUSED, rand_sample(), rand_sample(), rand_sample(),
                       LW'($urandom));
          1: query(LW'($urandom));
          2: begin send_item(CMD_CLEAR, '0, '0, '0, '0); i = 0; end
          default: ;
        endcase
        push_random();
      end
      nq = $urandom_range(1, 5);
      repeat (nq) begin
        if (width > 0 && $urandom_range(0, 4) != 0) query(LW'($urandom_range(0, width - 1)));
        else query(LW'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
